@@ design/mcbd_pkg.sv @@
// package for the mip chain box downsampler
// shared types and register indexes; no dependencies
package mcbd_pkg;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_WIDTH = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LIMIT = 2'd2;
	localparam int unsigned CfgDataW = 13;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic [3:0] level;
		logic [11:0] column;
		logic [11:0] row;
		logic run_end;
		logic chain_end;
	} res_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [CfgDataW-1:0] data;
	} cfg_t;
endpackage

@@ design/mcbd_if.sv @@
// handshake channel interfaces for the mip chain box downsampler
// depends on mcbd_pkg
interface mcbd_pix_if;
	logic valid;
	logic ready;
	mcbd_pkg::pix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mcbd_res_if;
	logic valid;
	logic ready;
	mcbd_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mcbd_cfg_if;
	logic valid;
	logic ready;
	mcbd_pkg::cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/mcbd_ram.sv @@
// generic single-port-write, single-read ram with registered read
// no dependencies
module mcbd_ram #(
	parameter int unsigned Width = 36,
	parameter int unsigned Depth = 4096
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(Depth)-1:0] wr_addr,
	input logic [Width-1:0] wr_data,
	input logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

@@ design/mip_chain_box_downsampler.sv @@
// channel  | dir | payload
// in       | in  | red, green, blue, alpha
// out      | out | pixel, level, column, row, run_end, chain_end
// cfg      | in  | index (0 width, 1 height, 2 level limit), 13-bit data
//
// an input whose chain stops at level 0 is accepted, then emitted; each further
// level is averaged, then emitted, when the level above is one row high, else
// the line ram is read, the pair averaged, then emitted
// after a config write a geometry pass computes each level's size and ram base
// a result waits in the output register; the walk stalls until it transfers
// reset clears counters and pending pixels; the line ram is not cleared
module mip_chain_box_downsampler #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_HEIGHT = 4096,
	parameter int unsigned MAX_LEVELS = 13
) (
	input logic clk,
	input logic arst_n,
	mcbd_pix_if.sink pix_in,
	mcbd_res_if.source res_out,
	mcbd_cfg_if.sink cfg
);
	import mcbd_pkg::*;

	localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int unsigned DW = 17;

	typedef enum logic [4:0] {
		ST_GEOM = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_EMIT = 5'b00100,
		ST_READ = 5'b01000,
		ST_AVG  = 5'b10000
	} state_t;

	state_t state_q;
	logic [12:0] width_q, height_q;
	logic [3:0] limit_q;
	logic [DW-1:0] dim_w_q [MAX_LEVELS];
	logic [DW-1:0] dim_h_q [MAX_LEVELS];
	logic [DW-1:0] base_q [MAX_LEVELS];
	logic [DW-1:0] col_q [MAX_LEVELS];
	logic [DW-1:0] row_q [MAX_LEVELS];
	logic [31:0] pend_q [MAX_LEVELS];
	logic [4:0] cap_q;
	logic [4:0] count_q;
	logic [LW-1:0] lv_q;
	logic [31:0] pix_q;
	logic frame_last_q;
	logic [35:0] pair_q;
	logic [DW-1:0] addr_q;
	logic [DW-1:0] geo_base_q;
	logic out_valid_q;
	logic emit_via_read_q;
	res_t out_q;

	// geometry helpers
	logic [DW-1:0] w0, h0, dmax;
	logic [4:0] full_cap, cap_sat;
	always_comb begin
		w0 = (width_q == '0) ? DW'(1) : (DW'(width_q) > DW'(MAX_WIDTH) ? DW'(MAX_WIDTH)
			: DW'(width_q));
		h0 = (height_q == '0) ? DW'(1) : (DW'(height_q) > DW'(MAX_HEIGHT)
			? DW'(MAX_HEIGHT) : DW'(height_q));
		dmax = (w0 > h0) ? w0 : h0;
		full_cap = 5'd1;
		for (int i = 1; i < DW; i++) begin
			if (dmax[i]) full_cap = 5'(i + 1);
		end
		cap_sat = (limit_q == '0) ? full_cap : 5'(limit_q);
		if (cap_sat > 5'(MAX_LEVELS)) cap_sat = 5'(MAX_LEVELS);
	end

	// current level view
	logic [DW-1:0] cur_col, cur_row, cur_w, cur_h, nx_w, nx_h, nx_base;
	logic last_lv, col_wrap;
	always_comb begin
		cur_col = col_q[lv_q];
		cur_row = row_q[lv_q];
		cur_w = dim_w_q[lv_q];
		cur_h = dim_h_q[lv_q];
		last_lv = (5'(lv_q) + 5'd1 >= count_q);
		nx_w = last_lv ? DW'(1) : dim_w_q[lv_q + LW'(1)];
		nx_h = last_lv ? DW'(1) : dim_h_q[lv_q + LW'(1)];
		nx_base = last_lv ? '0 : base_q[lv_q + LW'(1)];
		col_wrap = (cur_col + DW'(1) >= cur_w);
	end

	// horizontal pair
	logic [35:0] pair_c;
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (cur_w == DW'(1)) begin
				pair_c[9*c +: 9] = {pix_q[8*c +: 8], 1'b0};
			end else begin
				pair_c[9*c +: 9] = 9'(pix_q[8*c +: 8]) + 9'(pend_q[lv_q + LW'(1)][8*c +: 8]);
			end
		end
	end

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [35:0] ram_rdata;
	logic [DW-1:0] addr_c;
	assign addr_c = nx_base + (cur_col >> 1);

	mcbd_ram #(.Width(36), .Depth(MAX_WIDTH)) u_line (
		.clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(pair_c),
		.rd_addr(ram_raddr), .rd_data(ram_rdata)
	);

	// the emit decision for the current level
	typedef enum logic [2:0] {
		NX_STOP = 3'b001, NX_READ = 3'b010, NX_DIRECT = 3'b100
	} nx_t;
	nx_t nxt;
	logic pend_wr;
	always_comb begin
		nxt = NX_STOP;
		pend_wr = 1'b0;
		ram_we = 1'b0;
		if (!last_lv) begin
			if (cur_w != DW'(1) && cur_col >= (nx_w << 1)) begin
				nxt = NX_STOP;
			end else if (cur_w != DW'(1) && !cur_col[0]) begin
				pend_wr = 1'b1;
			end else if (cur_h == DW'(1)) begin
				nxt = NX_DIRECT;
			end else if (cur_row >= (nx_h << 1)) begin
				nxt = NX_STOP;
			end else if (!cur_row[0]) begin
				ram_we = (state_q == ST_EMIT) && res_out.ready && out_valid_q
					&& (addr_c < DW'(MAX_WIDTH));
			end else begin
				nxt = NX_READ;
			end
		end
		ram_waddr = AW'(addr_c);
		// the read cycle re-reads the address latched at the transfer
		ram_raddr = (state_q == ST_READ) ? AW'(addr_q) : AW'(addr_c);
	end

	// shared averaging unit
	logic [35:0] rd_word;
	logic [31:0] avg;
	always_comb begin
		rd_word = (state_q == ST_AVG && addr_q < DW'(MAX_WIDTH)) ? ram_rdata : '0;
		for (int c = 0; c < 4; c++) begin
			logic [10:0] s;
			if (state_q == ST_AVG) begin
				s = 11'(pair_q[9*c +: 9]) + 11'(rd_word[9*c +: 9]) + 11'd2;
			end else begin
				s = {pair_c[9*c +: 9], 1'b0} + 11'd2;
			end
			avg[8*c +: 8] = s[9:2];
		end
	end

	logic emit_fire;
	logic stop_c;
	assign emit_fire = (state_q == ST_EMIT) && out_valid_q && res_out.ready;
	assign stop_c = (nxt == NX_STOP) || pend_wr;
	assign pix_in.ready = (state_q == ST_IDLE) && !out_valid_q && !cfg.valid;
	assign cfg.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign res_out.valid = out_valid_q;
	// chain flags follow from registered state that holds while the result waits
	assign res_out.data = '{out_red: out_q.out_red, out_green: out_q.out_green,
		out_blue: out_q.out_blue, out_alpha: out_q.out_alpha, level: out_q.level,
		column: out_q.column, row: out_q.row, run_end: stop_c,
		chain_end: stop_c && frame_last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_GEOM;
			width_q <= 13'd1;
			height_q <= 13'd1;
			limit_q <= '0;
			cap_q <= '0;
			count_q <= 5'd1;
			lv_q <= '0;
			geo_base_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
				pend_q[i] <= '0;
				dim_w_q[i] <= DW'(1);
				dim_h_q[i] <= DW'(1);
				base_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_GEOM: begin
					if (lv_q == '0) begin
						dim_w_q[0] <= w0;
						dim_h_q[0] <= h0;
						cap_q <= cap_sat;
						count_q <= 5'd1;
						geo_base_q <= '0;
						lv_q <= LW'(1);
						if (cap_sat <= 5'd1 || MAX_LEVELS == 1) begin
							lv_q <= '0;
							state_q <= ST_IDLE;
						end
					end else begin
						logic [DW-1:0] w, h;
						w = (dim_w_q[lv_q - LW'(1)] >> 1) == '0 ? DW'(1)
							: dim_w_q[lv_q - LW'(1)] >> 1;
						h = (dim_h_q[lv_q - LW'(1)] >> 1) == '0 ? DW'(1)
							: dim_h_q[lv_q - LW'(1)] >> 1;
						dim_w_q[lv_q] <= w;
						dim_h_q[lv_q] <= h;
						base_q[lv_q] <= geo_base_q;
						geo_base_q <= geo_base_q + w;
						count_q <= 5'(lv_q) + 5'd1;
						if ((w == DW'(1) && h == DW'(1)) || 5'(lv_q) + 5'd1 >= cap_q
							|| 32'(lv_q) + 1 >= MAX_LEVELS) begin
							lv_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							lv_q <= lv_q + LW'(1);
						end
					end
				end
				ST_IDLE: begin
					if (cfg.valid && cfg.ready) begin
						case (cfg.data.index)
							REG_WIDTH: width_q <= cfg.data.data;
							REG_HEIGHT: height_q <= cfg.data.data;
							REG_LIMIT: limit_q <= cfg.data.data[3:0];
							default: ;
						endcase
						if (cfg.data.index == REG_WIDTH || cfg.data.index == REG_HEIGHT
							|| cfg.data.index == REG_LIMIT) begin
							state_q <= ST_GEOM;
							lv_q <= '0;
							for (int i = 0; i < MAX_LEVELS; i++) begin
								col_q[i] <= '0;
								row_q[i] <= '0;
								pend_q[i] <= '0;
							end
						end
					end else if (pix_in.valid && pix_in.ready) begin
						pix_q <= {pix_in.data.alpha, pix_in.data.blue, pix_in.data.green,
							pix_in.data.red};
						frame_last_q <= (col_q[0] == dim_w_q[0] - DW'(1))
							&& (row_q[0] == dim_h_q[0] - DW'(1));
						lv_q <= '0;
						out_valid_q <= 1'b1;
						out_q.out_red <= pix_in.data.red;
						out_q.out_green <= pix_in.data.green;
						out_q.out_blue <= pix_in.data.blue;
						out_q.out_alpha <= pix_in.data.alpha;
						out_q.level <= '0;
						out_q.column <= col_q[0][11:0];
						out_q.row <= row_q[0][11:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						out_valid_q <= 1'b0;
						if (col_wrap) begin
							col_q[lv_q] <= '0;
							row_q[lv_q] <= (cur_row + DW'(1) >= cur_h) ? '0 : cur_row + DW'(1);
						end else begin
							col_q[lv_q] <= cur_col + DW'(1);
						end
						if (pend_wr) pend_q[lv_q + LW'(1)] <= pix_q;
						pair_q <= pair_c;
						addr_q <= addr_c;
						if (pend_wr || nxt == NX_STOP) begin
							state_q <= ST_IDLE;
						end else if (nxt == NX_READ) begin
							state_q <= ST_READ;
						end else begin
							pix_q <= avg;
							lv_q <= lv_q + LW'(1);
							state_q <= ST_AVG;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_AVG;
					lv_q <= lv_q + LW'(1);
				end
				ST_AVG: begin
					// present the next level pixel; the read path averages here
					logic [31:0] v;
					v = emit_via_read_q ? avg : pix_q;
					pix_q <= v;
					out_valid_q <= 1'b1;
					out_q.out_red <= v[7:0];
					out_q.out_green <= v[15:8];
					out_q.out_blue <= v[23:16];
					out_q.out_alpha <= v[31:24];
					out_q.level <= 4'(lv_q);
					out_q.column <= cur_col[11:0];
					out_q.row <= cur_row[11:0];
					state_q <= ST_EMIT;
				end
				default: state_q <= ST_GEOM;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_via_read_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			emit_via_read_q <= 1'b1;
		end else if (state_q == ST_EMIT) begin
			emit_via_read_q <= 1'b0;
		end
	end
endmodule

@@ design/mcbd_checker.sv @@
// port-level checker for the mip chain box downsampler
// no dependencies; bound to the top level
module mcbd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_run_end,
	input logic [3:0] out_level,
	input logic cfg_ready
);
	// no input transfer while a result is still waiting
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// first result after an input transfer is level 0
	a_echo_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (out_valid && out_level == '0))
		else $error("source echo missing");
	// config never taken alongside a result
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !out_valid) else $error("config ready while busy");
	// valid holds until transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	// the run marker is always known on a valid result
	a_run_end_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_run_end)) else $error("run_end unknown");
endmodule

bind mip_chain_box_downsampler mcbd_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(pix_in.valid), .in_ready(pix_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_run_end(res_out.data.run_end), .out_level(res_out.data.level),
	.cfg_ready(cfg.ready)
);
